### src/filtered_object_fingerprint_hash_core_defines.svh
// ---------------------------------------------------------------------------
// filtered object fingerprint hash - assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef FILTERED_OBJECT_FINGERPRINT_HASH_CORE_DEFINES_SVH
`define FILTERED_OBJECT_FINGERPRINT_HASH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during rst
`define FFH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FFH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FFH_ASSERT_NOW(label, ante, cons, msg)
`define FFH_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### src/ffh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffh_pkg
// shared constants and types of the filtered object fingerprint hash
// ---------------------------------------------------------------------------
package ffh_pkg;

  // field and word widths
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 31;
  localparam int unsigned COUNT_W  = 32;

  // bytes folded per word and per record (index, address, flags)
  localparam int unsigned WORD_BYTES   = WORD_W / BYTE_W;
  localparam int unsigned RECORD_BYTES = 3 * WORD_BYTES;
  localparam int unsigned SR_W         = RECORD_BYTES * BYTE_W;
  localparam int unsigned CNT_W        = $clog2(RECORD_BYTES + 1);

  // fnv-1a 64: prime is 2^40 + 0x1b3
  localparam logic [WORD_W-1:0] FNV_BASIS       = 64'hCBF29CE484222325;
  localparam logic [8:0]        FNV_PRIME_LO    = 9'h1B3;
  localparam int unsigned       FNV_PRIME_SHIFT = 40;

  // murmur3 fmix64 constants
  localparam logic [WORD_W-1:0] MIX_K1    = 64'hFF51AFD7ED558CCD;
  localparam logic [WORD_W-1:0] MIX_K2    = 64'hC4CEB9FE1A85EC53;
  localparam int unsigned       MIX_SHIFT = 33;

  // fold unit control
  typedef struct packed {
    logic             load;
    logic             clear;
    logic [CNT_W-1:0] nbytes;
  } fnv_ctrl_t;

endpackage

### src/ffh_fnv.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffh_fnv
// byte-serial fnv-1a fold: a shift register hands one byte per cycle
// to a single round of xor and multiply by the fnv prime
// ---------------------------------------------------------------------------
module ffh_fnv (
  input  logic                          clk,
  input  logic                          rst,
  input  ffh_pkg::fnv_ctrl_t            ctrl,
  input  logic [ffh_pkg::SR_W-1:0]      load_data,
  output logic                          busy,
  output logic [ffh_pkg::WORD_W-1:0]    hash
);

  logic [ffh_pkg::SR_W-1:0]   sr;
  logic [ffh_pkg::CNT_W-1:0]  cnt;
  logic [ffh_pkg::WORD_W-1:0] mixed;
  logic [ffh_pkg::WORD_W-1:0] hash_next;

  assign busy = (cnt != '0);

  // one fnv round: xor the low byte, then multiply by 2^40 + 0x1b3
  assign mixed     = hash ^ {{(ffh_pkg::WORD_W-ffh_pkg::BYTE_W){1'b0}},
                             sr[ffh_pkg::BYTE_W-1:0]};
  assign hash_next = ffh_pkg::WORD_W'(mixed * ffh_pkg::FNV_PRIME_LO)
                   + {mixed[ffh_pkg::WORD_W-ffh_pkg::FNV_PRIME_SHIFT-1:0],
                      {ffh_pkg::FNV_PRIME_SHIFT{1'b0}}};

  // running hash and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= ffh_pkg::FNV_BASIS;
      cnt  <= '0;
    end else begin
      if (ctrl.clear) begin
        hash <= ffh_pkg::FNV_BASIS;
      end else if (busy) begin
        hash <= hash_next;
      end
      if (ctrl.load) begin
        cnt <= ctrl.nbytes;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // byte shift register, least significant byte first
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sr <= load_data;
    end else if (busy) begin
      sr <= sr >> ffh_pkg::BYTE_W;
    end
  end

endmodule

### src/ffh_fmix.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffh_fmix
// murmur3 fmix64 finaliser; each 64-bit product is built one constant
// byte per cycle by a 64 x 8 multiply and accumulate
// ---------------------------------------------------------------------------
module ffh_fmix (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ffh_pkg::WORD_W-1:0] din,
  output logic                       valid,
  output logic [ffh_pkg::WORD_W-1:0] result
);

  localparam int unsigned DIGITS = ffh_pkg::WORD_BYTES;
  localparam int unsigned DIG_W  = $clog2(DIGITS);
  localparam int unsigned PROD_W = ffh_pkg::WORD_W + ffh_pkg::BYTE_W;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL1,
    M_MID,
    M_MUL2,
    M_FIN,
    M_DONE
  } phase_t;

  phase_t                     phase;
  logic [ffh_pkg::WORD_W-1:0] mcand;
  logic [ffh_pkg::WORD_W-1:0] acc;
  logic [ffh_pkg::WORD_W-1:0] kreg;
  logic [DIG_W-1:0]           dig;
  logic [PROD_W-1:0]          prod;
  logic                       last_dig;

  // partial product of the shifted multiplicand and one constant byte
  assign prod     = mcand * kreg[ffh_pkg::BYTE_W-1:0];
  assign last_dig = (dig == DIG_W'(DIGITS - 1));
  assign valid    = (phase == M_DONE);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
    end else begin
      if (start) begin
        phase <= M_MUL1;
        mcand <= din ^ (din >> ffh_pkg::MIX_SHIFT);
        acc   <= '0;
        kreg  <= ffh_pkg::MIX_K1;
        dig   <= '0;
      end else begin
        case (phase)
          M_MUL1, M_MUL2: begin
            acc   <= acc + prod[ffh_pkg::WORD_W-1:0];
            mcand <= mcand << ffh_pkg::BYTE_W;
            kreg  <= kreg >> ffh_pkg::BYTE_W;
            dig   <= dig + 1'b1;
            if (last_dig) begin
              phase <= (phase == M_MUL1) ? M_MID : M_FIN;
            end
          end
          M_MID: begin
            mcand <= acc ^ (acc >> ffh_pkg::MIX_SHIFT);
            acc   <= '0;
            kreg  <= ffh_pkg::MIX_K2;
            dig   <= '0;
            phase <= M_MUL2;
          end
          M_FIN: begin
            result <= acc ^ (acc >> ffh_pkg::MIX_SHIFT);
            phase  <= M_DONE;
          end
          default: begin
            phase <= phase;
          end
        endcase
      end
    end
  end

endmodule

### src/filtered_object_fingerprint_hash_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// filtered_object_fingerprint_hash_core
// counts and fnv-1a hashes object records whose flags hit the type mask,
// and on finish folds the count, applies fmix64 and emits the fingerprint
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | mode, object_index, object_address,
//          |                       | type_flags
//  out     | out_valid / out_ready | type_count, fingerprint
//  cfg     | cfg_wr_en             | cfg_wr_data (type mask)
//
//  a matched record is accepted, then the fold unit folds its 24 bytes in
//  byte rounds; a record that misses the mask is accepted and not folded.
//  a finish runs in order: accept, a fold of the 8 count bytes, a hand-off,
//  two products of 8 byte steps each closed by an xor-shift, the output load.
//  the output register lets the next record in while a fingerprint waits.
//  rst clears the mask, the count and the hash to the fnv offset basis.
// ---------------------------------------------------------------------------
`include "filtered_object_fingerprint_hash_core_defines.svh"

module filtered_object_fingerprint_hash_core (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [ffh_pkg::WORD_W-1:0]  cfg_wr_data,
  // input transaction
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [ffh_pkg::INDEX_W-1:0] object_index,
  input  logic [ffh_pkg::WORD_W-1:0]  object_address,
  input  logic [ffh_pkg::WORD_W-1:0]  type_flags,
  // output transaction
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffh_pkg::COUNT_W-1:0] type_count,
  output logic [ffh_pkg::WORD_W-1:0]  fingerprint
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD_FIN,
    S_MIX
  } state_t;

  state_t                       state;
  logic [ffh_pkg::WORD_W-1:0]   type_mask;
  logic [ffh_pkg::COUNT_W-1:0]  match_count;
  logic [ffh_pkg::COUNT_W-1:0]  count_hold;

  ffh_pkg::fnv_ctrl_t           fnv_ctrl;
  logic [ffh_pkg::SR_W-1:0]     fnv_data;
  logic                         fnv_busy;
  logic [ffh_pkg::WORD_W-1:0]   fnv_hash;
  logic                         mix_start;
  logic                         mix_valid;
  logic [ffh_pkg::WORD_W-1:0]   mix_result;

  logic in_fire;
  logic rec_match;
  logic out_free;
  logic out_load;

  // handshake and control decode
  assign in_ready  = (state == S_IDLE) && !fnv_busy;
  assign in_fire   = in_valid && in_ready;
  assign rec_match = |(type_flags & type_mask);
  assign mix_start = (state == S_FOLD_FIN) && !fnv_busy;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_MIX) && mix_valid && out_free;

  // fold unit load: a matched record, or the count on finish
  always_comb begin
    fnv_ctrl.load   = in_fire && (mode || rec_match);
    fnv_ctrl.clear  = mix_start;
    fnv_ctrl.nbytes = mode ? ffh_pkg::CNT_W'(ffh_pkg::WORD_BYTES)
                           : ffh_pkg::CNT_W'(ffh_pkg::RECORD_BYTES);
    if (mode) begin
      fnv_data = {{(ffh_pkg::SR_W-ffh_pkg::COUNT_W){1'b0}}, match_count};
    end else begin
      fnv_data = {type_flags, object_address,
                  {(ffh_pkg::WORD_W-ffh_pkg::INDEX_W){1'b0}}, object_index};
    end
  end

  ffh_fnv u_fnv (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fnv_ctrl),
    .load_data (fnv_data),
    .busy      (fnv_busy),
    .hash      (fnv_hash)
  );

  ffh_fmix u_fmix (
    .clk    (clk),
    .rst    (rst),
    .start  (mix_start),
    .din    (fnv_hash),
    .valid  (mix_valid),
    .result (mix_result)
  );

  // state, count, mask and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      type_mask   <= '0;
      match_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        type_mask <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && mode) begin
            count_hold  <= match_count;
            match_count <= '0;
            state       <= S_FOLD_FIN;
          end else if (in_fire && rec_match) begin
            match_count <= match_count + 1'b1;
          end
        end
        S_FOLD_FIN: begin
          if (!fnv_busy) begin
            state <= S_MIX;
          end
        end
        S_MIX: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid   <= 1'b1;
        type_count  <= count_hold;
        fingerprint <= mix_result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  `FFH_ASSERT_NEXT(a_match_starts_fold, in_fire && !mode && rec_match, fnv_busy,
                   "matched record did not start the fold")
  `FFH_ASSERT_NEXT(a_finish_clears_count, in_fire && mode, match_count == '0,
                   "finish did not clear the count")
  `FFH_ASSERT_NOW(a_fold_idle_in_mix, state == S_MIX, !fnv_busy,
                  "fold unit running during finalise")
  `FFH_ASSERT_NEXT(a_out_load_sets_valid, out_load,
                   out_valid && fingerprint == $past(mix_result), "result not captured")

endmodule
